@@ hdl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_CLR = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RD_ROOT,
		RD_PARENT,
		RD_LAST,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [VAL_W-1:0]  item_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  out_value;
		logic                     out_valid;
		logic [1:0]               status;
		logic [CNT_OUT_W-1:0]     item_count;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    pos_count;
		logic    pos_zero;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_taken;
		logic    cap_last;
		logic    cap_left;
		logic    step_up;
		logic    step_down;
		logic    use_right;
		logic    place;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic no_left;
		logic no_right;
		logic up;
		logic sink;
	} dp_flags_t;

endpackage

@@ hdl/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/mhpq_dp.sv @@
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: entry count, sift position, moving value, heap RAM and
// the child/parent compares.
// ----------------------------------------------------------------------------
module mhpq_dp
	import mhpq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	input  logic signed [VAL_W-1:0] item_value,
	output dp_flags_t               flags,
	output logic signed [VAL_W-1:0] taken,
	output logic [CNT_OUT_W-1:0]    item_count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = AW + 2;

	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           pos_q;
	logic signed [VAL_W-1:0] v_q;
	logic signed [VAL_W-1:0] lv_q;
	logic signed [VAL_W-1:0] taken_q;

	logic [AW-1:0]           parent;
	logic [IW-1:0]           left_w;
	logic [IW-1:0]           right_w;
	logic [IW-1:0]           n_w;
	logic [AW-1:0]           left;
	logic [AW-1:0]           right;
	logic [AW-1:0]           last;
	logic [AW-1:0]           pick;
	logic                    take_right;
	logic signed [VAL_W-1:0] pval;
	logic signed [VAL_W-1:0] rd_data;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic signed [VAL_W-1:0] wr_data;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	assign parent  = (pos_q - AW'(1)) >> 1;
	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + IW'(1);
	assign n_w     = IW'(cnt_q);
	assign left    = left_w[AW-1:0];
	assign right   = right_w[AW-1:0];
	assign last    = AW'(cnt_q);

	// pick the right child when left >= right
	assign take_right = cmd.use_right && (lv_q >= rd_data);
	assign pval       = cmd.use_right ? (take_right ? rd_data : lv_q) : rd_data;
	assign pick       = take_right ? right : left;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ROOT:   rd_addr = '0;
			RD_PARENT: rd_addr = parent;
			RD_LAST:   rd_addr = last;
			RD_LEFT:   rd_addr = left;
			RD_RIGHT:  rd_addr = right;
			default:   rd_addr = '0;
		endcase
	end

	assign wr_en   = cmd.place || cmd.step_up || cmd.step_down;
	assign wr_data = cmd.place ? v_q : (cmd.step_up ? rd_data : pval);

	mhpq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_heap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_q),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			v_q <= item_value;
		end else if (cmd.cap_last) begin
			v_q <= rd_data;
		end
		if (cmd.pos_count) begin
			pos_q <= AW'(cnt_q);
		end else if (cmd.pos_zero) begin
			pos_q <= '0;
		end else if (cmd.step_up) begin
			pos_q <= parent;
		end else if (cmd.step_down) begin
			pos_q <= pick;
		end
		if (cmd.cap_left) begin
			lv_q <= rd_data;
		end
		if (cmd.cap_taken) begin
			taken_q <= rd_data;
		end
	end

	assign flags.full     = (cnt_q >= CW'(DEPTH));
	assign flags.empty    = (cnt_q == '0);
	assign flags.at_root  = (pos_q == '0);
	assign flags.no_left  = (left_w >= n_w);
	assign flags.no_right = (right_w >= n_w);
	assign flags.up       = (rd_data > v_q);
	assign flags.sink     = (v_q > pval);

	assign taken      = taken_q;
	assign cnt_ext    = {{CNT_OUT_W{1'b0}}, cnt_q};
	assign item_count = cnt_ext[CNT_OUT_W-1:0];

endmodule

@@ hdl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for enqueue sift-up, dequeue sift-down and the clear, no-op and rejected operations.
// ----------------------------------------------------------------------------
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [1:0] opcode,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd,
	output logic      busy,
	output logic      done,
	output logic      out_valid,
	output status_t   status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EU_CHK,
		S_EU_CMP,
		S_DQ_LAST,
		S_DQ_LOAD,
		S_SD_CHK,
		S_SD_LEFT,
		S_SD_RIGHT
	} state_t;

	state_t  state_q;
	logic    done_q;
	logic    valid_q;
	status_t status_q;
	op_t     op;

	assign op = op_t'(opcode);

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_ROOT;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_ENQ: begin
							if (!flags.full) begin
								cmd.load_item = 1'b1;
								cmd.pos_count = 1'b1;
								cmd.cnt_inc   = 1'b1;
							end
						end
						OP_DEQ: begin
							if (!flags.empty) begin
								cmd.rd_en   = 1'b1;
								cmd.rd_sel  = RD_ROOT;
								cmd.cnt_dec = 1'b1;
							end
						end
						OP_CLR:  cmd.cnt_clr = 1'b1;
						default: cmd = '0;
					endcase
				end
			end
			S_EU_CHK: begin
				if (flags.at_root) begin
					cmd.place = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PARENT;
				end
			end
			S_EU_CMP: begin
				if (flags.up) begin
					cmd.step_up = 1'b1;
				end else begin
					cmd.place = 1'b1;
				end
			end
			S_DQ_LAST: begin
				cmd.cap_taken = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_LAST;
				cmd.pos_zero  = 1'b1;
			end
			S_DQ_LOAD: cmd.cap_last = 1'b1;
			S_SD_CHK: begin
				if (flags.no_left) begin
					cmd.place = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
				end
			end
			S_SD_LEFT: begin
				cmd.cap_left = 1'b1;
				if (!flags.no_right) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
				end else if (flags.sink) begin
					cmd.step_down = 1'b1;
				end else begin
					cmd.place = 1'b1;
				end
			end
			S_SD_RIGHT: begin
				cmd.use_right = 1'b1;
				if (flags.sink) begin
					cmd.step_down = 1'b1;
				end else begin
					cmd.place = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			valid_q  <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						valid_q  <= 1'b0;
						status_q <= ST_OK;
						unique case (op)
							OP_ENQ: begin
								if (flags.full) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else begin
									state_q <= S_EU_CHK;
								end
							end
							OP_DEQ: begin
								if (flags.empty) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_DQ_LAST;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_EU_CHK: begin
					if (flags.at_root) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_EU_CMP;
					end
				end
				S_EU_CMP: begin
					if (flags.up) begin
						state_q <= S_EU_CHK;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_DQ_LAST: state_q <= S_DQ_LOAD;
				S_DQ_LOAD: state_q <= S_SD_CHK;
				S_SD_CHK: begin
					if (flags.no_left) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						valid_q <= 1'b1;
					end else begin
						state_q <= S_SD_LEFT;
					end
				end
				S_SD_LEFT: begin
					if (!flags.no_right) begin
						state_q <= S_SD_RIGHT;
					end else if (flags.sink) begin
						state_q <= S_SD_CHK;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						valid_q <= 1'b1;
					end
				end
				S_SD_RIGHT: begin
					if (flags.sink) begin
						state_q <= S_SD_CHK;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign out_valid = valid_q;
	assign status    = status_q;

endmodule

@@ hdl/min_heap_priority_queue.sv @@
// Sequence: clear, no-op, full enqueue and empty dequeue raise the beat straight from idle;
//   enqueue reads the parent at each level and climbs until it stops below the root or reaches it;
//   dequeue reads the root, then the last entry, then per level the left and any right child.
// Flow: one item at a time; start is taken only while idle. The receiver cannot stall.
// Reset: arst_n clears the controller and the entry count; heap RAM is not cleared.
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap priority queue: enqueue with sift-up, dequeue of the
// smallest value with sift-down, and clear. One result beat per item.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  in_item,
	output logic      done,
	output out_item_t result
);

	dp_cmd_t                 cmd;
	dp_flags_t               flags;
	logic signed [VAL_W-1:0] taken;
	logic [CNT_OUT_W-1:0]    item_count;
	logic                    out_valid;
	status_t                 status;

	// Sequencer: decode the opcode, walk the heap levels, raise the beat.
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (in_item.opcode),
		.flags     (flags),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.out_valid (out_valid),
		.status    (status)
	);

	// Datapath: hold the count, the moving value and the heap RAM.
	mhpq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_value (in_item.item_value),
		.flags      (flags),
		.taken      (taken),
		.item_count (item_count)
	);

	// Drop the removed value to zero unless this beat carries a dequeue.
	always_comb begin
		result.out_value  = out_valid ? taken : '0;
		result.out_valid  = out_valid;
		result.status     = status;
		result.item_count = item_count;
	end

endmodule
